[design/sst_pkg.sv]
// Shared types and constants for the sparse-set component table.
// Field widths, default sizing, operation and status codes.
// No dependencies.
package sst_pkg;

    // Fixed port field widths
    localparam int OP_W    = 2;
    localparam int ENT_W   = 10;
    localparam int DATA_W  = 64;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    // Default sizing
    localparam int DEF_MAX_ENTITIES = 1024;
    localparam int DEF_CAPACITY     = 1024;
    localparam int DEF_DATA_BITS    = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL = 2'd1;
    localparam logic [OP_W-1:0] OP_GET = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ     = 3'd3;
    localparam logic [STAT_W-1:0] ST_INVALID  = 3'd4;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd6;

endpackage

[design/sst_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
module sst_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/sst_ctrl.sv]
// Sequencer for the sparse-set table: reads the sparse map and dense store,
// decides the operation, writes back, and holds the result register.
// Depends on sst_pkg.
module sst_ctrl import sst_pkg::*; #(
    parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int DATA_BITS    = DEF_DATA_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // input channel
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic [OP_W-1:0]                            s_operation,
    input  logic [ENT_W-1:0]                           s_entity_index,
    input  logic                                       s_id_valid,
    input  logic [DATA_W-1:0]                          s_data_word,
    // result channel
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [STAT_W-1:0]                          m_status,
    output logic [DATA_W-1:0]                          m_read_data,
    output logic [SLOT_W-1:0]                          m_slot,
    output logic [COUNT_W-1:0]                         m_entry_count,
    // sparse map port
    output logic                                       map_we,
    output logic [$clog2(MAX_ENTITIES)-1:0]            map_waddr,
    output logic [$clog2(CAPACITY):0]                  map_wdata,
    output logic [$clog2(MAX_ENTITIES)-1:0]            map_raddr,
    input  logic [$clog2(CAPACITY):0]                  map_rdata,
    // dense store port: {owner, data}
    output logic                                       dense_we,
    output logic [$clog2(CAPACITY)-1:0]                dense_waddr,
    output logic [$clog2(MAX_ENTITIES)+DATA_BITS-1:0]  dense_wdata,
    output logic [$clog2(CAPACITY)-1:0]                dense_raddr,
    input  logic [$clog2(MAX_ENTITIES)+DATA_BITS-1:0]  dense_rdata
);

    localparam int IW = $clog2(MAX_ENTITIES);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAP   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [OP_W-1:0]      op_reg;
    logic [IW-1:0]        ent_reg;
    logic [DATA_BITS-1:0] word_reg;
    logic [SW-1:0]        slot_reg, slot_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]    m_status_reg, m_status_next;
    logic [DATA_W-1:0]    m_read_data_reg, m_read_data_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;
    logic [COUNT_W-1:0]   m_entry_count_reg, m_entry_count_next;

    logic                 accept;
    logic                 bad_id;
    logic                 load;
    logic                 map_hit;
    logic [SW-1:0]        map_slot;
    logic [CW-1:0]        last;

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign bad_id   = !s_id_valid
                   || (32'(s_entity_index) >= 32'(MAX_ENTITIES))
                   || !(s_operation inside {OP_SET, OP_DEL, OP_GET});
    assign map_hit  = map_rdata[SW];
    assign map_slot = map_rdata[SW-1:0];
    assign last     = cnt_reg - 1'b1;

    always_comb begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        cnt_next           = cnt_reg;
        slot_next          = slot_reg;
        load               = 1'b0;
        m_status_next      = m_status_reg;
        m_read_data_next   = '0;
        m_slot_next        = '0;
        m_entry_count_next = COUNT_W'(cnt_reg);
        map_we             = 1'b0;
        map_waddr          = ent_reg;
        map_wdata          = '0;
        map_raddr          = IW'(s_entity_index);
        dense_we           = 1'b0;
        dense_waddr        = map_slot;
        dense_wdata        = {ent_reg, word_reg};
        dense_raddr        = map_slot;

        case (state_reg)
            S_CLEAR: begin
                // sweep the sparse map to empty, one entry a cycle
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IW'(MAX_ENTITIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (bad_id) begin
                        load          = 1'b1;
                        m_status_next = ST_INVALID;
                    end else begin
                        state_next = S_MAP;
                    end
                end
            end
            S_MAP: begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_SET: begin
                        load = 1'b1;
                        if (map_hit) begin
                            dense_we      = 1'b1;
                            m_status_next = ST_UPDATED;
                            m_slot_next   = SLOT_W'(map_slot);
                        end else if (cnt_reg == CW'(CAPACITY)) begin
                            m_status_next = ST_FULL;
                        end else begin
                            // append at the end of the dense store
                            dense_we           = 1'b1;
                            dense_waddr        = cnt_reg[SW-1:0];
                            map_we             = 1'b1;
                            map_wdata          = {1'b1, cnt_reg[SW-1:0]};
                            cnt_next           = cnt_reg + 1'b1;
                            m_status_next      = ST_INSERTED;
                            m_slot_next        = SLOT_W'(cnt_reg);
                            m_entry_count_next = COUNT_W'(cnt_next);
                        end
                    end
                    OP_DEL: begin
                        if (!map_hit) begin
                            load          = 1'b1;
                            m_status_next = ST_ABSENT;
                        end else begin
                            map_we    = 1'b1;
                            slot_next = map_slot;
                            if (CW'(map_slot) == last) begin
                                // last entry: drop with no move
                                load               = 1'b1;
                                cnt_next           = last;
                                m_status_next      = ST_DELETED;
                                m_slot_next        = SLOT_W'(map_slot);
                                m_entry_count_next = COUNT_W'(last);
                            end else begin
                                dense_raddr = last[SW-1:0];
                                state_next  = S_MOVE;
                            end
                        end
                    end
                    OP_GET: begin
                        if (!map_hit) begin
                            load          = 1'b1;
                            m_status_next = ST_ABSENT;
                        end else begin
                            slot_next  = map_slot;
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        load          = 1'b1;
                        m_status_next = ST_INVALID;
                    end
                endcase
            end
            S_READ: begin
                load             = 1'b1;
                state_next       = S_IDLE;
                m_status_next    = ST_READ;
                m_read_data_next = DATA_W'(dense_rdata[DATA_BITS-1:0]);
                m_slot_next      = SLOT_W'(slot_reg);
            end
            S_MOVE: begin
                // move the last entry into the freed slot and repoint its owner
                load               = 1'b1;
                state_next         = S_IDLE;
                dense_we           = 1'b1;
                dense_waddr        = slot_reg;
                dense_wdata        = dense_rdata;
                map_we             = 1'b1;
                map_waddr          = dense_rdata[IW+DATA_BITS-1:DATA_BITS];
                map_wdata          = {1'b1, slot_reg};
                cnt_next           = last;
                m_status_next      = ST_DELETED;
                m_slot_next        = SLOT_W'(slot_reg);
                m_entry_count_next = COUNT_W'(last);
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_operation;
            ent_reg  <= IW'(s_entity_index);
            word_reg <= s_data_word[DATA_BITS-1:0];
        end
        slot_reg <= slot_next;
        if (load) begin
            m_status_reg      <= m_status_next;
            m_read_data_reg   <= m_read_data_next;
            m_slot_reg        <= m_slot_next;
            m_entry_count_reg <= m_entry_count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_slot        = m_slot_reg;
    assign m_entry_count = m_entry_count_reg;

`ifndef NO_ASSERTIONS
    // an accepted item either produces its result at once or keeps the block busy
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid_reg || (state_reg != S_IDLE))
        else $error("accepted item left no trace");

    // the entry count moves only together with a new result
    a_count_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (cnt_reg != $past(cnt_reg)) |-> $rose(m_valid_reg))
        else $error("entry count changed without a result");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) && (m_status_reg == ST_INSERTED)
        |-> cnt_reg == CW'($past(cnt_reg) + 1'b1))
        else $error("insert did not grow the table by one");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) && (m_status_reg == ST_DELETED)
        |-> cnt_reg == CW'($past(cnt_reg) - 1'b1))
        else $error("delete did not shrink the table by one");
`endif

endmodule

[design/sparse_set_swap_remove_table.sv]
// Sparse-set component table with swap-remove delete.
// Results: a rejected id is answered from S_IDLE; set, absent and last-entry delete
// from S_MAP after the map read; read and delete with a move from S_READ or S_MOVE.
// Items are accepted only in S_IDLE while the result register is free or being taken.
// Reset: count cleared, then a sweep of every entry empties the sparse map;
// s_ready stays low until it ends. Depends on sst_pkg, sst_ram, sst_ctrl.
module sparse_set_swap_remove_table import sst_pkg::*; #(
    parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int DATA_BITS    = DEF_DATA_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [ENT_W-1:0]     s_entity_index,
    input  logic                 s_id_valid,
    input  logic [DATA_W-1:0]    s_data_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STAT_W-1:0]    m_status,
    output logic [DATA_W-1:0]    m_read_data,
    output logic [SLOT_W-1:0]    m_slot,
    output logic [COUNT_W-1:0]   m_entry_count
);

    localparam int IW = $clog2(MAX_ENTITIES);
    localparam int SW = $clog2(CAPACITY);
    localparam int DW = IW + DATA_BITS;

    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic [SW:0]   map_wdata;
    logic [IW-1:0] map_raddr;
    logic [SW:0]   map_rdata;
    logic          dense_we;
    logic [SW-1:0] dense_waddr;
    logic [DW-1:0] dense_wdata;
    logic [SW-1:0] dense_raddr;
    logic [DW-1:0] dense_rdata;

    // entity index -> {valid, dense slot}
    sst_ram #(
        .DEPTH (MAX_ENTITIES),
        .WIDTH (SW + 1)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // dense slot -> {owner, data word}
    sst_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DW)
    ) u_dense (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    sst_ctrl #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .CAPACITY     (CAPACITY),
        .DATA_BITS    (DATA_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entity_index (s_entity_index),
        .s_id_valid     (s_id_valid),
        .s_data_word    (s_data_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_read_data    (m_read_data),
        .m_slot         (m_slot),
        .m_entry_count  (m_entry_count),
        .map_we         (map_we),
        .map_waddr      (map_waddr),
        .map_wdata      (map_wdata),
        .map_raddr      (map_raddr),
        .map_rdata      (map_rdata),
        .dense_we       (dense_we),
        .dense_waddr    (dense_waddr),
        .dense_wdata    (dense_wdata),
        .dense_raddr    (dense_raddr),
        .dense_rdata    (dense_rdata)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sparse_set_swap_remove_table: a directed table, then
// random set/delete/read traffic checked against a behavioral copy of the store.
// Depends on sst_pkg and the table RTL only.
module tb_top;
    import sst_pkg::*;

    localparam logic [OP_W-1:0] OP_BAD = 2'd3;   // unknown operation code
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIRECTED   = 22;
    localparam logic [DATA_W-1:0] ONES = '1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  read_data;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] entry_count;
    } store_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ENT_W-1:0]  ent;
        logic              idv;
        logic [DATA_W-1:0] word;
        logic              typed;
        store_result_t     res;
    } directed_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_operation = '0;
    logic [ENT_W-1:0] s_entity_index = '0;
    logic s_id_valid = 1'b0;
    logic [DATA_W-1:0] s_data_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [DATA_W-1:0] m_read_data;
    logic [SLOT_W-1:0] m_slot;
    logic [COUNT_W-1:0] m_entry_count;

    sparse_set_swap_remove_table i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entity_index (s_entity_index),
        .s_id_valid     (s_id_valid),
        .s_data_word    (s_data_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_read_data    (m_read_data),
        .m_slot         (m_slot),
        .m_entry_count  (m_entry_count)
    );

    always #4 aclk = ~aclk;

    // Behavioral copy of the store
    bit                entity_present [DEF_MAX_ENTITIES];
    bit [SLOT_W-1:0]   slot_of_entity [DEF_MAX_ENTITIES];
    bit [ENT_W-1:0]    owner_of_slot  [DEF_CAPACITY];
    bit [DATA_W-1:0]   word_of_slot   [DEF_CAPACITY];
    bit [COUNT_W-1:0]  stored_count;

    store_result_t pending_results [$];
    int errors = 0;
    int items_sent = 0;
    int status_seen [8];
    int peak_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;
    int perm [DEF_MAX_ENTITIES];

    function automatic store_result_t apply_store_op(input logic [OP_W-1:0] op,
                                                     input logic [ENT_W-1:0] ent,
                                                     input logic idv,
                                                     input logic [DATA_W-1:0] word);
        store_result_t r;
        bit [COUNT_W-1:0] s;
        bit [COUNT_W-1:0] last;
        bit [ENT_W-1:0] mover;
        r = '{ST_INVALID, '0, '0, stored_count};
        if (!idv || op == OP_BAD)
            return r;
        if (op == OP_SET) begin
            if (entity_present[ent]) begin
                s = COUNT_W'(slot_of_entity[ent]);
                word_of_slot[s] = word;
                r.status = ST_UPDATED;
                r.slot = s[SLOT_W-1:0];
            end else if (stored_count >= DEF_CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                s = stored_count;
                word_of_slot[s] = word;
                owner_of_slot[s] = ent;
                slot_of_entity[ent] = s[SLOT_W-1:0];
                entity_present[ent] = 1'b1;
                stored_count = s + 1'b1;
                r.status = ST_INSERTED;
                r.slot = s[SLOT_W-1:0];
                r.entry_count = stored_count;
            end
            return r;
        end
        if (!entity_present[ent]) begin
            r.status = ST_ABSENT;
            return r;
        end
        s = COUNT_W'(slot_of_entity[ent]);
        if (op == OP_GET) begin
            r.status = ST_READ;
            r.read_data = word_of_slot[s];
            r.slot = s[SLOT_W-1:0];
            return r;
        end
        // swap-remove: move the last entry into the freed slot
        last = stored_count - 1'b1;
        entity_present[ent] = 1'b0;
        if (s != last) begin
            mover = owner_of_slot[last];
            owner_of_slot[s] = mover;
            word_of_slot[s] = word_of_slot[last];
            slot_of_entity[mover] = s[SLOT_W-1:0];
        end
        stored_count = last;
        r.status = ST_DELETED;
        r.slot = s[SLOT_W-1:0];
        r.entry_count = stored_count;
        return r;
    endfunction

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OP_GET, 10'd5,    1'b1, 64'd0, 1'b1, '{ST_ABSENT,   64'd0, 10'd0, 11'd0}},
        '{OP_DEL, 10'd5,    1'b1, 64'd0, 1'b1, '{ST_ABSENT,   64'd0, 10'd0, 11'd0}},
        '{OP_BAD, 10'd0,    1'b1, 64'd0, 1'b1, '{ST_INVALID,  64'd0, 10'd0, 11'd0}},
        '{OP_SET, 10'd0,    1'b0, ONES,  1'b1, '{ST_INVALID,  64'd0, 10'd0, 11'd0}},
        '{OP_SET, 10'd0,    1'b1, 64'd0, 1'b1, '{ST_INSERTED, 64'd0, 10'd0, 11'd1}},
        '{OP_SET, 10'd1023, 1'b1, ONES,  1'b1, '{ST_INSERTED, 64'd0, 10'd1, 11'd2}},
        '{OP_GET, 10'd1023, 1'b1, 64'd0, 1'b1, '{ST_READ,     ONES,  10'd1, 11'd2}},
        '{OP_GET, 10'd1023, 1'b0, 64'd0, 1'b1, '{ST_INVALID,  64'd0, 10'd0, 11'd2}},
        '{OP_SET, 10'd0,    1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1,
          '{ST_UPDATED, 64'd0, 10'd0, 11'd2}},
        '{OP_GET, 10'd0,    1'b1, 64'd0, 1'b1,
          '{ST_READ, 64'hA5A5_A5A5_A5A5_A5A5, 10'd0, 11'd2}},
        '{OP_SET, 10'd512,  1'b1, 64'd1, 1'b1, '{ST_INSERTED, 64'd0, 10'd2, 11'd3}},
        '{OP_DEL, 10'd0,    1'b1, 64'd0, 1'b1, '{ST_DELETED,  64'd0, 10'd0, 11'd2}},
        '{OP_GET, 10'd512,  1'b1, 64'd0, 1'b0, '0},
        '{OP_GET, 10'd0,    1'b1, 64'd0, 1'b1, '{ST_ABSENT,   64'd0, 10'd0, 11'd2}},
        '{OP_DEL, 10'd512,  1'b1, 64'd0, 1'b0, '0},
        '{OP_DEL, 10'd1023, 1'b1, 64'd0, 1'b0, '0},
        '{OP_BAD, 10'd1023, 1'b0, ONES,  1'b1, '{ST_INVALID,  64'd0, 10'd0, 11'd0}},
        '{OP_SET, 10'd341,  1'b1, 64'h5555_5555_5555_5555, 1'b1,
          '{ST_INSERTED, 64'd0, 10'd0, 11'd1}},
        '{OP_SET, 10'd682,  1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
          '{ST_INSERTED, 64'd0, 10'd1, 11'd2}},
        '{OP_GET, 10'd341,  1'b1, 64'd0, 1'b0, '0},
        '{OP_DEL, 10'd682,  1'b1, 64'd0, 1'b0, '0},
        '{OP_GET, 10'd682,  1'b1, 64'd0, 1'b1, '{ST_ABSENT,   64'd0, 10'd0, 11'd1}}
    };

    // Present one item and hold it until accepted; the predicted or typed
    // result is queued at the accepting edge.
    task automatic push_op(input logic [OP_W-1:0] op, input logic [ENT_W-1:0] ent,
                           input logic idv, input logic [DATA_W-1:0] word,
                           input logic typed, input store_result_t typed_res);
        store_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_entity_index <= ent;
        s_id_valid     <= idv;
        s_data_word    <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_store_op(op, ent, idv, word);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic send_random(input int set_pct, input int del_pct, input int get_pct,
                               input int pool);
        int pick;
        logic [OP_W-1:0] op;
        logic [ENT_W-1:0] ent;
        logic idv;
        logic [DATA_W-1:0] word;
        pick = $urandom_range(0, 99);
        idv = 1'b1;
        if (pick < set_pct)
            op = OP_SET;
        else if (pick < set_pct + del_pct)
            op = OP_DEL;
        else if (pick < set_pct + del_pct + get_pct)
            op = OP_GET;
        else if ($urandom_range(0, 1) == 0) begin
            op = OP_BAD;
            idv = 1'($urandom_range(0, 1));
        end else begin
            op = OP_W'($urandom_range(0, 3));
            idv = 1'b0;
        end
        ent = ($urandom_range(0, 99) < 70) ? ENT_W'($urandom_range(0, pool - 1))
                                           : ENT_W'($urandom_range(0, DEF_MAX_ENTITIES - 1));
        case ($urandom_range(0, 15))
            0: word = '0;
            1: word = '1;
            default: word = {$urandom, $urandom};
        endcase
        push_op(op, ent, idv, word, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each result with the oldest outstanding prediction
    always @(posedge aclk) begin
        store_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding: status %0d", m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.status !== m_status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
                if (want.read_data !== m_read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, m_read_data);
                    errors++;
                end
                if (want.slot !== m_slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_slot);
                    errors++;
                end
                if (want.entry_count !== m_entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           m_entry_count);
                    errors++;
                end
            end
            status_seen[m_status]++;
            if (int'(m_entry_count) > peak_count)
                peak_count = int'(m_entry_count);
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("sparse_set_swap_remove_table: mismatch");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        int tmp;
        int j;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 76;
        for (int i = 0; i < N_DIRECTED; i++)
            push_op(directed_rows[i].op, directed_rows[i].ent, directed_rows[i].idv,
                    directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);

        // mixed traffic over a small entity pool so deletes and reads hit
        for (int i = 0; i < 300; i++)
            send_random(45, 20, 25, 48);

        // hold off until the pipeline is empty
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);

        // fill every entity in random order, up to a full dense array
        send_idle_pct = 76;
        recv_idle_pct = 38;
        for (int i = 0; i < DEF_MAX_ENTITIES; i++)
            perm[i] = i;
        for (int i = DEF_MAX_ENTITIES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < DEF_MAX_ENTITIES; i++) begin
            push_op(OP_SET, ENT_W'(perm[i]), 1'b1, {$urandom, $urandom}, 1'b0, '0);
            if (i % 8 == 7)
                send_random(0, 0, 80, DEF_MAX_ENTITIES);
        end

        // drain with delete-heavy traffic, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 250; i++)
            send_random(15, 50, 25, DEF_MAX_ENTITIES);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items: %0d inserts, %0d updates, %0d deletes, %0d reads,",
                 items_sent, status_seen[ST_INSERTED], status_seen[ST_UPDATED],
                 status_seen[ST_DELETED], status_seen[ST_READ]);
        $display("  %0d rejected ids, %0d misses; dense array peaked at %0d entries",
                 status_seen[ST_INVALID], status_seen[ST_ABSENT], peak_count);
        if (errors == 0)
            $display("sparse_set_swap_remove_table: match");
        else
            $display("sparse_set_swap_remove_table: mismatch");
        $finish;
    end

endmodule
